FILE: rtl/core/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Shared constants and codes for the sparse challenge sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

  localparam int COEFF_COUNT = 256;
  localparam int COEFF_AW    = 8;
  localparam int COEFF_W     = 2;
  localparam int FILL_W      = 9;
  localparam int HDR_W       = 4;
  localparam int TAU_W       = 7;
  localparam int SIGN_W      = 64;

  localparam logic [HDR_W-1:0]   SIGN_BYTES = 4'd8;
  localparam logic [TAU_W-1:0]   TAU_MIN    = 7'd1;
  localparam logic [TAU_W-1:0]   TAU_MAX    = 7'd64;
  localparam logic [TAU_W-1:0]   TAU_RESET  = 7'd39;
  localparam logic [FILL_W-1:0]  FILL_IDLE  = 9'd256;
  localparam logic [COEFF_AW:0]  FILL_MIN   = 9'd192;

  localparam logic [COEFF_W-1:0] COEF_ZERO  = 2'b00;
  localparam logic [COEFF_W-1:0] COEF_POS   = 2'b01;
  localparam logic [COEFF_W-1:0] COEF_NEG   = 2'b11;

  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/sparse_challenge_sampler_unit.sv
// ----------------------------------------------------------------------------
// sparse_challenge_sampler_unit
// Builds a sparse challenge polynomial with tau entries of plus or minus one
// from an expanded byte stream, and answers reads of stored coefficients.
// ----------------------------------------------------------------------------
// Path: a sign byte, rejected or ignored byte passes S_RESP alone on its way
// to the result, a coefficient read S_RDATA then S_RESP, and a placed byte
// S_MOVE, S_SIGN and S_RESP, set by the read, move and sign write through the single coefficient RAM port pair.
// Throughput: one item at a time; the input is ready again once its result
// is loaded into the output register, which holds it until transfer.
// Reset: synchronous, active low; clears control, valid bits and tau to 39.
`default_nettype none

module sparse_challenge_sampler_unit
  import scs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // data_byte[7:0], start_new[8], read_index[16:9], zero pad
  input  wire logic [23:0] in_tdata,
  // command[0]
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // coefficient[1:0], accepted[2], done_res[3], zero pad
  output logic [7:0]       out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [TAU_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_SIGN,
    S_RDATA,
    S_RESP
  } state_t;

  state_t               state_r;
  logic [TAU_W-1:0]     tau_r;
  logic [FILL_W-1:0]    fill_r;
  logic [HDR_W-1:0]     hdr_r;
  logic [SIGN_W-1:0]    sign_r;
  logic [COEFF_COUNT-1:0] valid_r;
  logic                 out_valid_r;
  logic [7:0]           out_data_r;
  logic [COEFF_AW-1:0]  byte_r;
  logic [COEFF_AW-1:0]  idx_r;
  logic [COEFF_W-1:0]   res_coef_r;
  logic                 res_acc_r;

  logic                 in_xfer;
  logic                 cmd_in;
  logic [COEFF_AW-1:0]  byte_in;
  logic                 start_in;
  logic [COEFF_AW-1:0]  idx_in;
  logic [TAU_W-1:0]     tau_sat;
  logic [FILL_W-1:0]    fill_eff;
  logic [HDR_W-1:0]     hdr_eff;
  logic                 ram_we;
  logic [COEFF_AW-1:0]  ram_waddr;
  logic [COEFF_W-1:0]   ram_wdata;
  logic [COEFF_AW-1:0]  ram_raddr;
  logic [COEFF_W-1:0]   ram_rdata;
  logic [COEFF_W-1:0]   moved_coef;
  logic [COEFF_W-1:0]   read_coef;
  logic [COEFF_W-1:0]   sign_coef;
  logic                 out_free;

  assign cmd_in   = in_tuser;
  assign byte_in  = in_tdata[7:0];
  assign start_in = in_tdata[8];
  assign idx_in   = in_tdata[16:9];

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    priority if (tau_r < TAU_MIN) begin
      tau_sat = TAU_MIN;
    end else if (tau_r > TAU_MAX) begin
      tau_sat = TAU_MAX;
    end else begin
      tau_sat = tau_r;
    end
  end

  always_comb begin
    if (cmd_in == CMD_FEED && start_in) begin
      fill_eff = FILL_IDLE - {2'b00, tau_sat};
      hdr_eff  = '0;
    end else begin
      fill_eff = fill_r;
      hdr_eff  = hdr_r;
    end
  end

  assign ram_raddr  = (cmd_in == CMD_READ) ? idx_in : byte_in;
  assign moved_coef = valid_r[byte_r] ? ram_rdata : COEF_ZERO;
  assign read_coef  = valid_r[idx_r] ? ram_rdata : COEF_ZERO;
  assign sign_coef  = sign_r[0] ? COEF_NEG : COEF_POS;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = byte_r;
    ram_wdata = sign_coef;
    unique case (state_r)
      S_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = fill_r[COEFF_AW-1:0];
        ram_wdata = moved_coef;
      end
      S_SIGN: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  scs_ram #(
    .WIDTH(COEFF_W),
    .DEPTH(COEFF_COUNT)
  ) u_coeff_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tau_r       <= TAU_RESET;
      fill_r      <= FILL_IDLE;
      hdr_r       <= '0;
      sign_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tau_r <= cfg_data;
      end
      if (state_r == S_RESP && out_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {4'b0000, (hdr_r == SIGN_BYTES) && fill_r[COEFF_AW], res_acc_r,
                        res_coef_r};
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer) begin
        byte_r     <= byte_in;
        idx_r      <= idx_in;
        res_coef_r <= COEF_ZERO;
        res_acc_r  <= 1'b0;
      end
      if (state_r == S_RDATA) begin
        res_coef_r <= read_coef;
      end
      if (state_r == S_SIGN) begin
        res_acc_r <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (cmd_in == CMD_READ) begin
              state_r <= S_RDATA;
            end else begin
              fill_r <= fill_eff;
              if (start_in) begin
                valid_r <= '0;
              end
              priority if (fill_eff[COEFF_AW]) begin
                state_r <= S_RESP;
              end else if (hdr_eff < SIGN_BYTES) begin
                if (start_in) begin
                  sign_r <= {{(SIGN_W-8){1'b0}}, byte_in};
                end else begin
                  sign_r[{hdr_eff[2:0], 3'b000} +: 8] <= byte_in;
                end
                hdr_r   <= hdr_eff + 4'd1;
                state_r <= S_RESP;
              end else if ({1'b0, byte_in} > fill_eff) begin
                state_r <= S_RESP;
              end else begin
                state_r <= S_MOVE;
              end
            end
          end
        end
        S_MOVE: begin
          valid_r[fill_r[COEFF_AW-1:0]] <= 1'b1;
          state_r <= S_SIGN;
        end
        S_SIGN: begin
          valid_r[byte_r] <= 1'b1;
          sign_r  <= sign_r >> 1;
          fill_r  <= fill_r + 9'd1;
          state_r <= S_RESP;
        end
        S_RDATA: begin
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_hdr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_r <= SIGN_BYTES)
    else $error("header count beyond the sign word");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r >= FILL_MIN && fill_r <= FILL_IDLE)
    else $error("fill position out of range");

  a_sign_after_move: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOVE |=> state_r == S_SIGN)
    else $error("sign write did not follow the move");

  a_place_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SIGN |-> hdr_r == SIGN_BYTES && !fill_r[COEFF_AW])
    else $error("coefficient placed outside an active stream");

endmodule

`default_nettype wire

FILE: rtl/core/scs_ram.sv
// ----------------------------------------------------------------------------
// scs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
